>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset as disable
`define PPF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ppf assertion failed");

// antecedent holds, consequent in the next cycle
`define PPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	`PPF_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/ppf_pkg.sv
// types and constants of the pure pursuit path follower
package ppf_pkg;

	localparam int POS_W    = 32;
	localparam int VEL_W    = 25;
	localparam int SLOT_W   = 6;
	localparam int SPEED_W  = 24;
	localparam int PERIOD_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int MUL_W    = 34;
	localparam int ITER_W   = 6;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOKAHEAD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd5;

	// configuration reset values
	localparam logic [POS_W-1:0]    RST_START_X   = 32'hFFF6_0000;
	localparam logic [POS_W-1:0]    RST_START_Y   = 32'd0;
	localparam logic [POS_W-1:0]    RST_START_Z   = 32'd98304;
	localparam logic [SPEED_W-1:0]  RST_SPEED     = 24'd131072;
	localparam logic [SPEED_W-1:0]  RST_LOOKAHEAD = 24'd78643;
	localparam logic [PERIOD_W-1:0] RST_PERIOD    = 16'd2185;

	// item opcode
	localparam logic OPC_TICK = 1'b0;
	localparam logic OPC_LOAD = 1'b1;

	// iterations of the square root and of each division
	localparam logic [ITER_W-1:0] ITER_COUNT = 6'd34;

	// axis select
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DECODE, ST_LOAD, ST_INIT, ST_LA2, ST_DIFF, ST_SQX, ST_SQY,
		ST_SQZ, ST_SUM, ST_DECIDE, ST_SQRT_INIT, ST_SQRT_STEP, ST_STEP, ST_MUL,
		ST_DIV_INIT, ST_DIV_STEP, ST_DIV_WB, ST_SNAP, ST_OUT
	} ppf_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_LOAD, OP_INIT, OP_LA2, OP_DIFF, OP_SQX, OP_SQY,
		OP_SQZ, OP_SUM, OP_SQRT_INIT, OP_SQRT_STEP, OP_STEP, OP_MUL, OP_DIV_INIT,
		OP_DIV_STEP, OP_DIV_WB, OP_SNAP, OP_OUT
	} ppf_op_t;

	typedef struct packed {
		ppf_op_t    op;
		logic [1:0] axis;
		logic       move;
	} ppf_cmd_t;

	typedef struct packed {
		logic is_load;
		logic path_ok;
		logic hit;
		logic last;
		logic near;
		logic step_ge;
		logic iter_last;
		logic out_busy;
	} ppf_status_t;

endpackage

>>> rtl/ppf_in_if.sv
// input item channel: one tick or one trajectory point per beat
interface ppf_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [5:0]  point_index;
	logic [31:0] point_x;
	logic [31:0] point_y;
	logic [31:0] point_z;
	logic        point_is_last;

	modport source (output valid, opcode, point_index, point_x, point_y, point_z,
		point_is_last, input ready);
	modport sink (input valid, opcode, point_index, point_x, point_y, point_z,
		point_is_last, output ready);
endinterface

>>> rtl/ppf_out_if.sv
// result channel: position, velocity and chased slot after a tick
interface ppf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [24:0] vel_x;
	logic [24:0] vel_y;
	logic [24:0] vel_z;
	logic [5:0]  target_slot;
	logic        moving;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		target_slot, moving, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
		target_slot, moving, output ready);
endinterface

>>> rtl/ppf_ctrl.sv
// sequencer of the path follower: load, scan, square root, divisions, result
module ppf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  ppf_pkg::ppf_status_t st,
	output ppf_pkg::ppf_cmd_t    cmd
);

	ppf_pkg::ppf_state_t state_q, state_d;
	logic [1:0] axis_q, axis_d;
	logic       move_q, move_d;

	// state, axis and move registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppf_pkg::ST_IDLE;
			axis_q  <= ppf_pkg::AXIS_X;
			move_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
			move_q  <= move_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		axis_d  = axis_q;
		move_d  = move_q;
		unique case (state_q)
			ppf_pkg::ST_IDLE: if (item_valid) state_d = ppf_pkg::ST_DECODE;
			ppf_pkg::ST_DECODE: state_d = st.is_load ? ppf_pkg::ST_LOAD : ppf_pkg::ST_INIT;
			ppf_pkg::ST_LOAD: state_d = ppf_pkg::ST_IDLE;
			ppf_pkg::ST_INIT: state_d = st.path_ok ? ppf_pkg::ST_LA2 : ppf_pkg::ST_OUT;
			ppf_pkg::ST_LA2: state_d = ppf_pkg::ST_DIFF;
			ppf_pkg::ST_DIFF: state_d = ppf_pkg::ST_SQX;
			ppf_pkg::ST_SQX: state_d = ppf_pkg::ST_SQY;
			ppf_pkg::ST_SQY: state_d = ppf_pkg::ST_SQZ;
			ppf_pkg::ST_SQZ: state_d = ppf_pkg::ST_SUM;
			ppf_pkg::ST_SUM: state_d = (st.hit || st.last) ? ppf_pkg::ST_DECIDE
				: ppf_pkg::ST_DIFF;
			ppf_pkg::ST_DECIDE: state_d = st.near ? ppf_pkg::ST_OUT
				: ppf_pkg::ST_SQRT_INIT;
			ppf_pkg::ST_SQRT_INIT: state_d = ppf_pkg::ST_SQRT_STEP;
			ppf_pkg::ST_SQRT_STEP: if (st.iter_last) state_d = ppf_pkg::ST_STEP;
			ppf_pkg::ST_STEP: begin
				state_d = ppf_pkg::ST_MUL;
				axis_d  = ppf_pkg::AXIS_X;
				move_d  = 1'b0;
			end
			ppf_pkg::ST_MUL: state_d = ppf_pkg::ST_DIV_INIT;
			ppf_pkg::ST_DIV_INIT: state_d = ppf_pkg::ST_DIV_STEP;
			ppf_pkg::ST_DIV_STEP: if (st.iter_last) state_d = ppf_pkg::ST_DIV_WB;
			ppf_pkg::ST_DIV_WB: begin
				priority if (!move_q && !st.step_ge) begin
					move_d  = 1'b1;
					state_d = ppf_pkg::ST_MUL;
				end else if (axis_q == ppf_pkg::AXIS_Z) begin
					state_d = st.step_ge ? ppf_pkg::ST_SNAP : ppf_pkg::ST_OUT;
				end else begin
					axis_d  = axis_q + 2'd1;
					move_d  = 1'b0;
					state_d = ppf_pkg::ST_MUL;
				end
			end
			ppf_pkg::ST_SNAP: state_d = ppf_pkg::ST_OUT;
			ppf_pkg::ST_OUT: if (!st.out_busy) state_d = ppf_pkg::ST_IDLE;
			default: state_d = ppf_pkg::ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.axis   = axis_q;
		cmd.move   = move_q;
		item_ready = (state_q == ppf_pkg::ST_IDLE);
		unique case (state_q)
			ppf_pkg::ST_IDLE:      cmd.op = item_valid ? ppf_pkg::OP_CAPTURE : ppf_pkg::OP_NONE;
			ppf_pkg::ST_LOAD:      cmd.op = ppf_pkg::OP_LOAD;
			ppf_pkg::ST_INIT:      cmd.op = ppf_pkg::OP_INIT;
			ppf_pkg::ST_LA2:       cmd.op = ppf_pkg::OP_LA2;
			ppf_pkg::ST_DIFF:      cmd.op = ppf_pkg::OP_DIFF;
			ppf_pkg::ST_SQX:       cmd.op = ppf_pkg::OP_SQX;
			ppf_pkg::ST_SQY:       cmd.op = ppf_pkg::OP_SQY;
			ppf_pkg::ST_SQZ:       cmd.op = ppf_pkg::OP_SQZ;
			ppf_pkg::ST_SUM:       cmd.op = ppf_pkg::OP_SUM;
			ppf_pkg::ST_SQRT_INIT: cmd.op = ppf_pkg::OP_SQRT_INIT;
			ppf_pkg::ST_SQRT_STEP: cmd.op = ppf_pkg::OP_SQRT_STEP;
			ppf_pkg::ST_STEP:      cmd.op = ppf_pkg::OP_STEP;
			ppf_pkg::ST_MUL:       cmd.op = ppf_pkg::OP_MUL;
			ppf_pkg::ST_DIV_INIT:  cmd.op = ppf_pkg::OP_DIV_INIT;
			ppf_pkg::ST_DIV_STEP:  cmd.op = ppf_pkg::OP_DIV_STEP;
			ppf_pkg::ST_DIV_WB:    cmd.op = ppf_pkg::OP_DIV_WB;
			ppf_pkg::ST_SNAP:      cmd.op = ppf_pkg::OP_SNAP;
			ppf_pkg::ST_OUT:       cmd.op = st.out_busy ? ppf_pkg::OP_NONE : ppf_pkg::OP_OUT;
			default:               cmd.op = ppf_pkg::OP_NONE;
		endcase
	end

endmodule

>>> rtl/ppf_dp.sv
// datapath: path memory, position, shared multiplier, square root and divider
module ppf_dp #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppf_pkg::ppf_cmd_t    cmd,
	output ppf_pkg::ppf_status_t st,
	// item payload
	input  logic                 opcode,
	input  logic [5:0]           point_index,
	input  logic [31:0]          point_x,
	input  logic [31:0]          point_y,
	input  logic [31:0]          point_z,
	input  logic                 point_is_last,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [ppf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ppf_pkg::CFG_DATA_W-1:0] cfg_data,
	// result
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic [31:0]          pos_x,
	output logic [31:0]          pos_y,
	output logic [31:0]          pos_z,
	output logic [24:0]          vel_x,
	output logic [24:0]          vel_y,
	output logic [24:0]          vel_z,
	output logic [5:0]           target_slot,
	output logic                 moving
);

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam longint STOP_RAW = ((longint'(1) << FRAC_BITS) * 5 + 50) / 100;
	localparam logic [65:0] STOP_SQ = 66'(STOP_RAW) * 66'(STOP_RAW);
	localparam int MW = ppf_pkg::MUL_W;

	// configuration registers
	logic [31:0] start_q [3];
	logic [23:0] speed_q, look_q;
	logic [15:0] period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q[0] <= ppf_pkg::RST_START_X;
			start_q[1] <= ppf_pkg::RST_START_Y;
			start_q[2] <= ppf_pkg::RST_START_Z;
			speed_q    <= ppf_pkg::RST_SPEED;
			look_q     <= ppf_pkg::RST_LOOKAHEAD;
			period_q   <= ppf_pkg::RST_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ppf_pkg::CFG_START_X:   start_q[0] <= cfg_data;
				ppf_pkg::CFG_START_Y:   start_q[1] <= cfg_data;
				ppf_pkg::CFG_START_Z:   start_q[2] <= cfg_data;
				ppf_pkg::CFG_SPEED:     speed_q    <= cfg_data[23:0];
				ppf_pkg::CFG_LOOKAHEAD: look_q     <= cfg_data[23:0];
				ppf_pkg::CFG_PERIOD:    period_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// captured item
	logic        opc_q, last_flag_q;
	logic [5:0]  pidx_q;
	logic [95:0] pdata_q;

	always_ff @(posedge clk) begin
		if (cmd.op == ppf_pkg::OP_CAPTURE) begin
			opc_q       <= opcode;
			pidx_q      <= point_index;
			pdata_q     <= {point_z, point_y, point_x};
			last_flag_q <= point_is_last;
		end
	end

	// path memory, read data registered
	logic [95:0]   mem [MAX_POINTS];
	logic [95:0]   rd_q;
	logic [AW-1:0] idx_q;
	logic          wr_ok;

	assign wr_ok = (32'(pidx_q) < MAX_POINTS);

	always_ff @(posedge clk) begin
		if (cmd.op == ppf_pkg::OP_LOAD && wr_ok) mem[AW'(pidx_q)] <= pdata_q;
		if (cmd.op == ppf_pkg::OP_LA2) rd_q <= mem[AW'(0)];
		else if (cmd.op == ppf_pkg::OP_SUM) rd_q <= mem[idx_q + AW'(1)];
	end

	// path count and valid flag
	logic [CW-1:0] count_q;
	logic          pvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			pvalid_q <= 1'b0;
		end else if (cmd.op == ppf_pkg::OP_LOAD && wr_ok) begin
			if (pidx_q == 6'd0) pvalid_q <= 1'b0;
			if (last_flag_q) begin
				count_q  <= CW'(32'(pidx_q) + 32'd1);
				pvalid_q <= 1'b1;
			end
		end
	end

	// shared multiplier
	logic [MW-1:0]   mul_a, mul_b;
	logic [2*MW-1:0] p_q;
	logic signed [32:0] d_q [3];
	logic [32:0]     mag [3];
	logic [39:0]     step_q;
	logic            mul_en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = d_q[i][32] ? 33'(-d_q[i]) : 33'(d_q[i]);
		end
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (cmd.op)
			ppf_pkg::OP_INIT: begin
				mul_a = MW'(look_q);
				mul_b = MW'(look_q);
			end
			ppf_pkg::OP_SQX: begin
				mul_a = MW'(mag[0]);
				mul_b = MW'(mag[0]);
			end
			ppf_pkg::OP_SQY: begin
				mul_a = MW'(mag[1]);
				mul_b = MW'(mag[1]);
			end
			ppf_pkg::OP_SQZ: begin
				mul_a = MW'(mag[2]);
				mul_b = MW'(mag[2]);
			end
			ppf_pkg::OP_SQRT_INIT: begin
				mul_a = MW'(speed_q);
				mul_b = MW'(period_q);
			end
			ppf_pkg::OP_MUL: begin
				mul_a = MW'(mag[cmd.axis]);
				mul_b = cmd.move ? step_q[MW-1:0] : MW'(speed_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mul_en) p_q <= mul_a * mul_b;
	end

	// scan: differences, squared sum, lookahead compare
	logic [47:0] la2_q;
	logic [65:0] sum_q, sum_nx;
	logic [95:0] pt_q;
	logic [31:0] cur_q [3];
	logic [31:0] old_q [3];
	logic        started_q;

	assign sum_nx = sum_q + p_q[65:0];

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ppf_pkg::OP_LA2: la2_q <= p_q[47:0];
			ppf_pkg::OP_DIFF: begin
				pt_q <= rd_q;
				for (int i = 0; i < 3; i++) begin
					d_q[i] <= $signed({rd_q[32*i+31], rd_q[32*i +: 32]})
						- $signed({cur_q[i][31], cur_q[i]});
				end
			end
			ppf_pkg::OP_SQY: sum_q <= p_q[65:0];
			ppf_pkg::OP_SQZ, ppf_pkg::OP_SUM: sum_q <= sum_nx;
			default: ;
		endcase
	end

	// scan index
	always_ff @(posedge clk) begin
		if (cmd.op == ppf_pkg::OP_INIT) idx_q <= '0;
		else if (cmd.op == ppf_pkg::OP_SUM && !st.hit && !st.last) idx_q <= idx_q + AW'(1);
	end

	// square root, one result bit a cycle
	logic [67:0]     rad_q;
	logic [MW-1:0]   root_q;
	logic [36:0]     srem_q, srem_sh, s_trial;
	logic [ppf_pkg::ITER_W-1:0] cnt_q;

	assign srem_sh = {srem_q[34:0], rad_q[67:66]};
	assign s_trial = {1'b0, root_q, 2'b01};

	// restoring divider by the root, one quotient bit a cycle
	logic [MW-1:0] drem_q, quo_q;
	logic [MW:0]   d_sh;
	logic          d_ge;

	assign d_sh = {drem_q, quo_q[MW-1]};
	assign d_ge = (d_sh >= {1'b0, root_q});

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ppf_pkg::OP_SQRT_INIT: begin
				rad_q  <= {2'b00, sum_q};
				root_q <= '0;
				srem_q <= '0;
				cnt_q  <= ppf_pkg::ITER_COUNT;
			end
			ppf_pkg::OP_SQRT_STEP: begin
				rad_q <= {rad_q[65:0], 2'b00};
				cnt_q <= cnt_q - 1'b1;
				if (srem_sh >= s_trial) begin
					srem_q <= srem_sh - s_trial;
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					srem_q <= srem_sh;
					root_q <= {root_q[MW-2:0], 1'b0};
				end
			end
			ppf_pkg::OP_STEP: step_q <= p_q[FRAC_BITS +: 40];
			ppf_pkg::OP_DIV_INIT: begin
				drem_q <= p_q[2*MW-1:MW];
				quo_q  <= p_q[MW-1:0];
				cnt_q  <= ppf_pkg::ITER_COUNT;
			end
			ppf_pkg::OP_DIV_STEP: begin
				cnt_q  <= cnt_q - 1'b1;
				drem_q <= d_ge ? MW'(d_sh - {1'b0, root_q}) : d_sh[MW-1:0];
				quo_q  <= {quo_q[MW-2:0], d_ge};
			end
			default: ;
		endcase
	end

	// position, velocity and start flag
	logic [24:0] vel_q [3];
	logic        neg;

	assign neg = d_q[cmd.axis][32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			for (int i = 0; i < 3; i++) cur_q[i] <= '0;
		end else begin
			unique case (cmd.op)
				ppf_pkg::OP_INIT: begin
					started_q <= 1'b1;
					if (!started_q) begin
						for (int i = 0; i < 3; i++) cur_q[i] <= start_q[i];
					end
				end
				ppf_pkg::OP_DIV_WB: begin
					if (cmd.move) begin
						cur_q[cmd.axis] <= neg ? cur_q[cmd.axis] - 32'(quo_q)
							: cur_q[cmd.axis] + 32'(quo_q);
					end
				end
				ppf_pkg::OP_SNAP: begin
					for (int i = 0; i < 3; i++) cur_q[i] <= pt_q[32*i +: 32];
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ppf_pkg::OP_INIT) begin
			for (int i = 0; i < 3; i++) begin
				vel_q[i] <= '0;
				old_q[i] <= started_q ? cur_q[i] : start_q[i];
			end
		end else if (cmd.op == ppf_pkg::OP_DIV_WB && !cmd.move) begin
			vel_q[cmd.axis] <= neg ? 25'(-25'(quo_q)) : 25'(quo_q);
		end
	end

	// result register
	logic res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (cmd.op == ppf_pkg::OP_OUT) res_valid_q <= 1'b1;
		else if (res_ready) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == ppf_pkg::OP_OUT) begin
			pos_x       <= cur_q[0];
			pos_y       <= cur_q[1];
			pos_z       <= cur_q[2];
			vel_x       <= vel_q[0];
			vel_y       <= vel_q[1];
			vel_z       <= vel_q[2];
			target_slot <= 6'(idx_q);
			moving      <= (cur_q[0] != old_q[0]) || (cur_q[1] != old_q[1])
				|| (cur_q[2] != old_q[2]);
		end
	end

	assign res_valid = res_valid_q;

	// status to the sequencer
	always_comb begin
		st.is_load   = (opc_q == ppf_pkg::OPC_LOAD);
		st.path_ok   = pvalid_q && (count_q != '0);
		st.hit       = ({18'd0, la2_q} <= sum_nx);
		st.last      = ((32'(idx_q) + 32'd1) == 32'(count_q));
		st.near      = (sum_q <= STOP_SQ);
		st.step_ge   = (step_q >= {6'd0, root_q});
		st.iter_last = (cnt_q == ppf_pkg::ITER_W'(1));
		st.out_busy  = res_valid_q && !res_ready;
	end

endmodule

>>> rtl/pure_pursuit_path_follower.sv
// top level of the 3D pure pursuit path follower
//
//  channel  | dir | handshake         | payload
//  item     | in  | valid / ready     | opcode, point_index, point_x/y/z, point_is_last
//  result   | out | valid / ready     | pos_x/y/z, vel_x/y/z, target_slot, moving
//  cfg      | in  | cfg_we (no wait)  | cfg_idx, cfg_data
//
// a load beat writes one point into the path memory; a tick scans the points
// from slot 0 until one lies at or beyond the lookahead or the last is reached
// (no scan with no valid path), then, when the target is beyond the stop radius,
// takes the square root and 3 or 6 divisions, snapping the position onto the
// target when the step reaches it. the one multiplier and divider are shared.
// one beat is worked at a time; a finished result waits in its output register
// while the next beat is taken. no clearing pass after reset.
module pure_pursuit_path_follower #(
	parameter int MAX_POINTS = 64,
	parameter int FRAC_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,
	ppf_in_if.sink    item,
	ppf_out_if.source result,
	input  logic                                cfg_we,
	input  logic [ppf_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ppf_pkg::CFG_DATA_W-1:0] cfg_data
);

	ppf_pkg::ppf_cmd_t    cmd;
	ppf_pkg::ppf_status_t st;

	// sequencer
	ppf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.st         (st),
		.cmd        (cmd)
	);

	// datapath
	ppf_dp #(
		.MAX_POINTS (MAX_POINTS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.opcode        (item.opcode),
		.point_index   (item.point_index),
		.point_x       (item.point_x),
		.point_y       (item.point_y),
		.point_z       (item.point_z),
		.point_is_last (item.point_is_last),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.pos_x         (result.pos_x),
		.pos_y         (result.pos_y),
		.pos_z         (result.pos_z),
		.vel_x         (result.vel_x),
		.vel_y         (result.vel_y),
		.vel_z         (result.vel_z),
		.target_slot   (result.target_slot),
		.moving        (result.moving)
	);

endmodule

>>> rtl/ppf_checker.sv
// port-level checks of the path follower, bound to the top level
`include "assert_macros.svh"

module ppf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_opcode,
	input logic        result_valid,
	input logic        result_ready,
	input logic [31:0] result_pos_x,
	input logic [5:0]  result_target_slot
);

	// a stalled result beat holds its payload
	`PPF_ASSERT_NEXT(a_res_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result_pos_x) && $stable(result_target_slot))

	// one beat in work at a time: ready drops after an accepted beat
	`PPF_ASSERT_NEXT(a_one_beat, clk, arst_n, item_valid && item_ready, !item_ready)

	// a load beat raises no result while it is decoded and loaded
	`PPF_ASSERT_NEXT(a_load_quiet, clk, arst_n,
		item_valid && item_ready && (item_opcode == ppf_pkg::OPC_LOAD),
		!$rose(result_valid) ##1 !$rose(result_valid))

endmodule

bind pure_pursuit_path_follower ppf_checker u_ppf_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.item_opcode        (item.opcode),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_pos_x       (result.pos_x),
	.result_target_slot (result.target_slot)
);
